[rtl/core/timed_transition_table_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the timed transition table
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TIMED_TRANSITION_TABLE_TOP_MACROS_SVH
`define TIMED_TRANSITION_TABLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TTT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TTT_ASSERT_NEVER(lbl, cond, msg) `TTT_ASSERT(lbl, !(cond), msg)
`else
`define TTT_ASSERT(lbl, prop, msg)
`define TTT_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

[rtl/core/ttt_pkg.sv]
// ----------------------------------------------------------------------------
// Timed transition table package
// Field widths, input kinds, sequencer states and the divider response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ttt_pkg;

    localparam int SLOT_W    = 4;
    localparam int TIME_W    = 32;
    localparam int FRAME_W   = 24;
    localparam int PROG_W    = 18;
    localparam int FRAC_BITS = 16;

    localparam logic [PROG_W-1:0] PROG_MAX = '1;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_APPEND,
        ST_TK_SLOT,
        ST_TK_LOAD,
        ST_TK_DIV,
        ST_TK_EMIT,
        ST_TK_MOVE
    } state_t;

    typedef struct packed {
        logic              done;
        logic [PROG_W-1:0] quot;
    } div_rsp_t;

endpackage

[rtl/core/ttt_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/ttt_div.sv]
// ----------------------------------------------------------------------------
// Progress divider
// Restoring division giving floor(dividend * 2^16 / divisor), saturated,
// one quotient bit per cycle through a single shared subtractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "timed_transition_table_top_macros.svh"

module ttt_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ttt_pkg::TIME_W-1:0] dividend,
    input  logic [ttt_pkg::TIME_W-1:0] divisor,
    output ttt_pkg::div_rsp_t          rsp
);

    localparam int TW    = ttt_pkg::TIME_W;
    localparam int PW    = ttt_pkg::PROG_W;
    localparam int FB    = ttt_pkg::FRAC_BITS;
    localparam int CNT_W = $clog2(PW + 1);

    logic             busy_reg,  busy_next;
    logic             done_reg,  done_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [TW-1:0]    rem_reg,   rem_next;
    logic [PW-1:0]    sh_reg,    sh_next;
    logic [TW-1:0]    d_reg,     d_next;
    logic [PW-1:0]    quot_reg,  quot_next;

    logic [TW:0]      trial;
    logic [TW+1:0]    diff;
    logic             ge;
    logic             saturate;

    // The quotient only fits in PW bits when dividend < 4 * divisor.
    assign saturate = (divisor == '0) ||
                      ({2'b00, dividend} >= {divisor, 2'b00});
    assign trial    = {rem_reg, sh_reg[PW-1]};
    assign diff     = {1'b0, trial} - {2'b00, d_reg};
    assign ge       = !diff[TW+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        d_next    = d_reg;
        quot_next = quot_reg;
        if (start)
        begin
            d_next = divisor;
            if (saturate)
            begin
                quot_next = ttt_pkg::PROG_MAX;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = {2'b00, dividend[TW-1:2]};
                sh_next   = {dividend[1:0], {FB{1'b0}}};
                quot_next = '0;
                cnt_next  = CNT_W'(PW);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[TW-1:0] : trial[TW-1:0];
            quot_next = {quot_reg[PW-2:0], ge};
            sh_next   = {sh_reg[PW-2:0], 1'b0};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        sh_reg   <= sh_next;
        d_reg    <= d_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    `TTT_ASSERT(a_div_start_idle, start |-> !busy_reg, "divider started while busy")
    `TTT_ASSERT_NEVER(a_div_done_busy, done_reg && busy_reg, "divider done while busy")
    `TTT_ASSERT(a_div_busy_cnt, busy_reg |-> (cnt_reg != '0), "divider busy with no steps left")

endmodule

[rtl/core/timed_transition_table_top.sv]
// ----------------------------------------------------------------------------
// Timed transition table
// Keeps up to SLOTS timed transitions in an active list and reports their
// progress on every frame tick.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the s_axis channel. tuser carries the kind: a start
// (re)arms one slot with a duration in microseconds, a tick advances every
// active transition by the frame time. A start produces no result; a tick
// produces one result per list entry visited on the m_axis channel, in walk
// order, with tlast on the final one and tuser set when the transition has
// ended and been dropped from the list. A tick with no active entry is
// silent.
// Sequence. The block takes one item at a time. A start removes the slot
// from the list if it was active and then appends it. A tick visits each
// entry with a list read, a table read, the progress divider (one quotient
// bit per cycle for 18 bits) and a result. An entry whose progress
// saturates skips the bit-by-bit division, and an entry that has ended is
// followed by a move step that puts the last list entry into its place.
// Reset clears the active flags and the count; the slot stores need no
// clearing. Each result sits in an output register; when the receiver stalls
// the walk simply waits at that result, and an item may be accepted while
// the last result of a tick is still waiting to be taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "timed_transition_table_top_macros.svh"

module timed_transition_table_top #(
    parameter int SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // slot[3:0], duration[35:4], frame_us[59:36]
    input  logic [0:0]  s_axis_tuser,   // kind[0]
    // Results.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // slot_id[3:0], progress[21:4]
    output logic [0:0]  m_axis_tuser,   // ended[0]
    output logic        m_axis_tlast
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = ttt_pkg::SLOT_W;
    localparam int TW = ttt_pkg::TIME_W;
    localparam int FW = ttt_pkg::FRAME_W;
    localparam int PW = ttt_pkg::PROG_W;
    localparam int FB = ttt_pkg::FRAC_BITS;

    // Input fields as they sit in the transfer.
    logic [SW-1:0] in_slot;
    logic [TW-1:0] in_dur;
    logic [FW-1:0] in_ft;
    logic          in_kind;
    logic          in_range;

    assign in_slot  = s_axis_tdata[SW-1:0];
    assign in_dur   = s_axis_tdata[SW+TW-1:SW];
    assign in_ft    = s_axis_tdata[SW+TW+FW-1:SW+TW];
    assign in_kind  = s_axis_tuser[0];
    assign in_range = (32'(in_slot) < 32'(SLOTS));

    // Control state.
    ttt_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    cnt_reg,    cnt_next;
    logic [CW-1:0]    i_reg,      i_next;
    logic [SLOTS-1:0] active_reg, active_next;
    logic             out_valid_reg, out_valid_next;

    // Payload registers.
    logic [IW-1:0] slot_reg, slot_next;
    logic [TW-1:0] dur_reg;
    logic [FW-1:0] ft_reg;
    logic [TW-1:0] el_reg;
    logic [SW-1:0] out_slot_reg;
    logic [PW-1:0] out_prog_reg;
    logic          out_end_reg;
    logic          out_last_reg;

    // Memory ports.
    logic          ord_we,  pos_we,  el_we,  dur_we;
    logic [IW-1:0] ord_waddr, ord_wdata, ord_raddr, ord_rdata;
    logic [IW-1:0] pos_waddr, pos_wdata, pos_raddr, pos_rdata;
    logic [IW-1:0] tbl_raddr;
    logic [TW-1:0] el_wdata, el_rdata, dur_rdata;

    // Divider.
    logic              div_start;
    ttt_pkg::div_rsp_t div_rsp;

    // Walk helpers.
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] i_inc;
    logic          last_entry;
    logic          ended;
    logic [TW:0]   sum_ext;
    logic [TW-1:0] el_sat;
    logic          in_take;
    logic          out_load;
    logic          out_free;

    assign cnt_m1     = cnt_reg - CW'(1);
    assign i_inc      = i_reg + CW'(1);
    assign last_entry = (i_inc >= cnt_reg);
    // Progress of one or more means elapsed has reached the duration.
    assign ended      = (div_rsp.quot[PW-1:FB] != '0);
    assign sum_ext    = {1'b0, el_reg} + (TW + 1)'(ft_reg);
    assign el_sat     = sum_ext[TW] ? '1 : sum_ext[TW-1:0];
    assign out_free   = !out_valid_reg || m_axis_tready;
    assign in_take    = s_axis_tvalid && s_axis_tready;

    ttt_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_order_ram (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    ttt_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    ttt_ram #(.WIDTH(TW), .DEPTH(SLOTS)) u_elapsed_ram (
        .clk   (clk),
        .we    (el_we),
        .waddr (slot_reg),
        .wdata (el_wdata),
        .raddr (tbl_raddr),
        .rdata (el_rdata)
    );

    ttt_ram #(.WIDTH(TW), .DEPTH(SLOTS)) u_duration_ram (
        .clk   (clk),
        .we    (dur_we),
        .waddr (slot_reg),
        .wdata (dur_reg),
        .raddr (tbl_raddr),
        .rdata (dur_rdata)
    );

    // The divider samples both operands straight from the table read ports
    // in the cycle it is started.
    ttt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (el_rdata),
        .divisor  (dur_rdata),
        .rsp      (div_rsp)
    );

    // Sequencer: next state, memory controls and result loading.
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        i_next        = i_reg;
        slot_next     = slot_reg;
        active_next   = active_reg;
        s_axis_tready = 1'b0;
        ord_we        = 1'b0;
        ord_waddr     = '0;
        ord_wdata     = '0;
        ord_raddr     = '0;
        pos_we        = 1'b0;
        pos_waddr     = '0;
        pos_wdata     = '0;
        pos_raddr     = '0;
        el_we         = 1'b0;
        el_wdata      = '0;
        dur_we        = 1'b0;
        tbl_raddr     = '0;
        div_start     = 1'b0;
        out_load      = 1'b0;

        unique case (state_reg)
            ttt_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    slot_next = IW'(in_slot);
                    i_next    = '0;
                    if (in_kind == ttt_pkg::KIND_START)
                    begin
                        pos_raddr = IW'(in_slot);
                        ord_raddr = cnt_m1[IW-1:0];
                        if (in_range)
                        begin
                            state_next = active_reg[IW'(in_slot)] ? ttt_pkg::ST_REMOVE
                                                                 : ttt_pkg::ST_APPEND;
                        end
                    end
                    else if (cnt_reg != '0)
                    begin
                        ord_raddr  = '0;
                        state_next = ttt_pkg::ST_TK_SLOT;
                    end
                end
            end

            ttt_pkg::ST_REMOVE:
            begin
                // Move the last list entry into the slot's old place.
                ord_we                = 1'b1;
                ord_waddr             = pos_rdata;
                ord_wdata             = ord_rdata;
                pos_we                = 1'b1;
                pos_waddr             = ord_rdata;
                pos_wdata             = pos_rdata;
                active_next[slot_reg] = 1'b0;
                cnt_next              = cnt_m1;
                state_next            = ttt_pkg::ST_APPEND;
            end

            ttt_pkg::ST_APPEND:
            begin
                if (32'(cnt_reg) < 32'(SLOTS))
                begin
                    el_we                 = 1'b1;
                    el_wdata              = '0;
                    dur_we                = 1'b1;
                    pos_we                = 1'b1;
                    pos_waddr             = slot_reg;
                    pos_wdata             = cnt_reg[IW-1:0];
                    ord_we                = 1'b1;
                    ord_waddr             = cnt_reg[IW-1:0];
                    ord_wdata             = slot_reg;
                    active_next[slot_reg] = 1'b1;
                    cnt_next              = cnt_reg + CW'(1);
                end
                state_next = ttt_pkg::ST_IDLE;
            end

            ttt_pkg::ST_TK_SLOT:
            begin
                slot_next  = ord_rdata;
                tbl_raddr  = ord_rdata;
                state_next = ttt_pkg::ST_TK_LOAD;
            end

            ttt_pkg::ST_TK_LOAD:
            begin
                div_start  = 1'b1;
                state_next = ttt_pkg::ST_TK_DIV;
            end

            ttt_pkg::ST_TK_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ttt_pkg::ST_TK_EMIT;
                end
            end

            ttt_pkg::ST_TK_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (ended)
                    begin
                        ord_raddr  = cnt_m1[IW-1:0];
                        state_next = ttt_pkg::ST_TK_MOVE;
                    end
                    else
                    begin
                        el_we     = 1'b1;
                        el_wdata  = el_sat;
                        i_next    = i_inc;
                        ord_raddr = i_inc[IW-1:0];
                        state_next = last_entry ? ttt_pkg::ST_IDLE : ttt_pkg::ST_TK_SLOT;
                    end
                end
            end

            ttt_pkg::ST_TK_MOVE:
            begin
                // The moved entry takes this place and is handled next, unless the ended entry was the last one.
                ord_we                = 1'b1;
                ord_waddr             = i_reg[IW-1:0];
                ord_wdata             = ord_rdata;
                pos_we                = 1'b1;
                pos_waddr             = ord_rdata;
                pos_wdata             = i_reg[IW-1:0];
                active_next[slot_reg] = 1'b0;
                cnt_next              = cnt_m1;
                slot_next             = ord_rdata;
                tbl_raddr             = ord_rdata;
                state_next = (i_reg >= cnt_m1) ? ttt_pkg::ST_IDLE : ttt_pkg::ST_TK_LOAD;
            end

            default:
            begin
                state_next = ttt_pkg::ST_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ttt_pkg::ST_IDLE;
            cnt_reg       <= '0;
            i_reg         <= '0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            i_reg         <= i_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        if (in_take)
        begin
            dur_reg <= in_dur;
            ft_reg  <= in_ft;
        end
        if (state_reg == ttt_pkg::ST_TK_LOAD)
        begin
            el_reg <= el_rdata;
        end
        if (out_load)
        begin
            out_slot_reg <= SW'(slot_reg);
            out_prog_reg <= div_rsp.quot;
            out_end_reg  <= ended;
            out_last_reg <= last_entry;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(24 - PW - SW){1'b0}}, out_prog_reg, out_slot_reg};
    assign m_axis_tuser  = out_end_reg;
    assign m_axis_tlast  = out_last_reg;

    `TTT_ASSERT(a_count_matches_flags, (state_reg == ttt_pkg::ST_IDLE) |-> ($countones(active_reg) == 32'(cnt_reg)), "active count disagrees with slot flags")
    `TTT_ASSERT(a_count_bound, 32'(cnt_reg) <= 32'(SLOTS), "active count above slot count")
    `TTT_ASSERT(a_div_done_state, div_rsp.done |-> (state_reg == ttt_pkg::ST_TK_DIV), "divider result outside the divide wait")
    `TTT_ASSERT(a_emit_holds, ((state_reg == ttt_pkg::ST_TK_EMIT) && !out_free) |=> (state_reg == ttt_pkg::ST_TK_EMIT), "walk moved on while the result register was full")

endmodule

[tb/timed_transition_table_checker.sv]
// ----------------------------------------------------------------------------
// Timed transition table checker
// Watches both stream channels, keeps its own copy of the slot table and
// compares every result transfer with the oldest predicted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timed_transition_table_checker
    import ttt_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // slot[3:0], duration[35:4], frame_us[59:36]
    input  logic [0:0]  s_axis_tuser,   // kind[0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // slot_id[3:0], progress[21:4]
    input  logic [0:0]  m_axis_tuser,   // ended[0]
    input  logic        m_axis_tlast,
    output int          errors,
    output int          outstanding
);

    typedef struct packed {
        logic [SLOT_W-1:0] slot_id;
        logic [PROG_W-1:0] progress;
        logic              ended;
        logic              last;
    } report_t;

    localparam int PRINT_CAP = 40;

    report_t           pending_reports [$];
    logic              running         [SLOTS];
    logic [TIME_W-1:0] elapsed         [SLOTS];
    logic [TIME_W-1:0] span            [SLOTS];
    logic [SLOT_W-1:0] walk_order      [SLOTS];
    logic [SLOT_W-1:0] walk_index      [SLOTS];
    int unsigned       live_count;

    initial
    begin
        errors      = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string msg);
        if (errors < PRINT_CAP)
            $display("%0t ns: mismatch: %s", $time, msg);
        errors++;
    endtask

    // Fraction of the duration already spent, in Q2.16, clipped at the top.
    function automatic logic [PROG_W-1:0] fraction_done(input logic [TIME_W-1:0] el,
                                                        input logic [TIME_W-1:0] dur);
        logic [63:0] q;
        if (dur == '0)
            return PROG_MAX;
        q = {{(64-TIME_W-FRAC_BITS){1'b0}}, el, {FRAC_BITS{1'b0}}} /
            {{(64-TIME_W){1'b0}}, dur};
        if (q > {{(64-PROG_W){1'b0}}, PROG_MAX})
            return PROG_MAX;
        return q[PROG_W-1:0];
    endfunction

    // Removal fills the hole with the last entry of the list.
    task automatic unlink(input int unsigned at);
        logic [SLOT_W-1:0] moved;
        if (live_count == 0 || at >= live_count)
            return;
        live_count--;
        moved             = walk_order[live_count];
        walk_order[at]    = moved;
        walk_index[moved] = at[SLOT_W-1:0];
    endtask

    task automatic arm_slot(input logic [SLOT_W-1:0] slot, input logic [TIME_W-1:0] dur);
        if (running[slot])
        begin
            running[slot] = 1'b0;
            unlink(walk_index[slot]);
        end
        if (live_count >= SLOTS)
            return;
        elapsed[slot]          = '0;
        span[slot]             = dur;
        running[slot]          = 1'b1;
        walk_index[slot]       = live_count[SLOT_W-1:0];
        walk_order[live_count] = slot;
        live_count++;
    endtask

    // One frame: every entry reports once; an entry moved into a freed place
    // is visited in the same walk. The final report carries the last flag.
    task automatic advance_frame(input logic [FRAME_W-1:0] ft);
        int unsigned       pos;
        logic [SLOT_W-1:0] s;
        logic [TIME_W:0]   sum;
        report_t           r;
        report_t           held;
        logic              have_held;
        pos       = 0;
        have_held = 1'b0;
        while (pos < live_count)
        begin
            s          = walk_order[pos];
            r.slot_id  = s;
            r.progress = fraction_done(elapsed[s], span[s]);
            r.last     = 1'b0;
            if (elapsed[s] >= span[s])
            begin
                r.ended    = 1'b1;
                running[s] = 1'b0;
                unlink(pos);
            end
            else
            begin
                r.ended    = 1'b0;
                sum        = {1'b0, elapsed[s]} + {{(TIME_W+1-FRAME_W){1'b0}}, ft};
                elapsed[s] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                pos++;
            end
            if (have_held)
                pending_reports.push_back(held);
            held      = r;
            have_held = 1'b1;
        end
        if (have_held)
        begin
            held.last = 1'b1;
            pending_reports.push_back(held);
        end
    endtask

    task automatic check_report();
        report_t want;
        if (pending_reports.size() == 0)
        begin
            report_mismatch($sformatf("result for slot %0d with none expected",
                                      m_axis_tdata[3:0]));
            return;
        end
        want = pending_reports.pop_front();
        if (m_axis_tdata[3:0] !== want.slot_id)
            report_mismatch($sformatf("slot_id %0d, expected %0d",
                                      m_axis_tdata[3:0], want.slot_id));
        if (m_axis_tdata[21:4] !== want.progress)
            report_mismatch($sformatf("slot %0d progress %0d, expected %0d",
                                      want.slot_id, m_axis_tdata[21:4], want.progress));
        if (m_axis_tuser[0] !== want.ended)
            report_mismatch($sformatf("slot %0d ended %b, expected %b",
                                      want.slot_id, m_axis_tuser[0], want.ended));
        if (m_axis_tlast !== want.last)
            report_mismatch($sformatf("slot %0d tlast %b, expected %b",
                                      want.slot_id, m_axis_tlast, want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reports.delete();
            for (int k = 0; k < SLOTS; k++)
                running[k] = 1'b0;
            live_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_report();
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser[0] == KIND_TICK)
                    advance_frame(s_axis_tdata[59:36]);
                else
                    arm_slot(s_axis_tdata[3:0], s_axis_tdata[35:4]);
            end
            outstanding = pending_reports.size();
        end
    end

endmodule

[tb/timed_transition_table_top_test.sv]
// ----------------------------------------------------------------------------
// Timed transition table regression
// Drives start and tick transfers into the table, stalls both channels at
// random save in the last phase, and leaves result checks to the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timed_transition_table_top_test;

    import ttt_pkg::*;

    localparam int SLOTS = 16;
    // Well above the slowest plausible run: some 160 items, each tick at
    // most sixteen results plus receiver stalls.
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 400;
    localparam int RANDOM_PER_PHASE = 38;
    localparam int SOAK_TICKS = 20;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;    // slot[3:0], duration[35:4], frame_us[59:36]
    logic [0:0]  s_axis_tuser  = '0;    // kind[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // slot_id[3:0], progress[21:4]
    logic [0:0]  m_axis_tuser;          // ended[0]
    logic        m_axis_tlast;

    // Percentages of cycles in which the sender holds back or the receiver
    // refuses a transfer; changed from phase to phase.
    int          send_gap   = 13;
    int          recv_stall = 79;
    int          errors;
    int          outstanding;
    int unsigned cycles     = 0;

    timed_transition_table_top #(
        .SLOTS (SLOTS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    timed_transition_table_checker #(
        .SLOTS (SLOTS)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .errors        (errors),
        .outstanding   (outstanding)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // The receiver decides afresh at every falling edge whether to take a
    // result at the next rising edge.
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timed_transition_table_top regression: fail");
            $finish;
        end
    end

    // One input transfer. Inputs change only at the falling edge, and valid
    // is lowered only when a gap is really taken, so it is never dropped and
    // raised within the same time step.
    task automatic send_item(input logic kind, input logic [SLOT_W-1:0] slot,
                             input logic [TIME_W-1:0] dur, input logic [FRAME_W-1:0] ft);
        @(negedge clk);
        if ($urandom_range(0, 99) < send_gap)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < send_gap);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, ft, dur, slot};
        s_axis_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // The fields that an item ignores are filled with random bits, so that
    // they toggle without affecting the result.
    task automatic start_slot(input logic [SLOT_W-1:0] slot, input logic [TIME_W-1:0] dur);
        send_item(KIND_START, slot, dur, FRAME_W'($urandom_range(0, 24'hFFFFFF)));
    endtask

    task automatic tick_frame(input logic [FRAME_W-1:0] ft);
        send_item(KIND_TICK, SLOT_W'($urandom_range(0, SLOTS-1)), $urandom, ft);
    endtask

    // Most durations and frame times are of similar size, so that entries
    // end after a few ticks and the list keeps filling and draining; now and
    // then a zero or a fully random value reaches the extremes.
    task automatic random_item();
        logic [TIME_W-1:0]  dur;
        logic [FRAME_W-1:0] ft;
        case ($urandom_range(0, 9))
            0:       dur = '0;
            1:       dur = $urandom;
            2:       dur = $urandom_range(1, 20);
            default: dur = $urandom_range(0, 6000);
        endcase
        case ($urandom_range(0, 9))
            0:       ft = '0;
            1:       ft = FRAME_W'($urandom_range(0, 24'hFFFFFF));
            default: ft = FRAME_W'($urandom_range(0, 2500));
        endcase
        if ($urandom_range(0, 99) < 35)
            tick_frame(ft);
        else
            start_slot(SLOT_W'($urandom_range(0, SLOTS-1)), dur);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. A tick on an empty list must stay silent.
        tick_frame(24'hFFFFFF);
        start_slot(4'd0, '0);
        start_slot(4'd15, '1);
        start_slot(4'd5, 32'd1000);
        // Re-arming slot 15 takes it out of the middle of the list, so the
        // last entry (slot 5) moves into its place before 15 is appended.
        start_slot(4'd15, 32'd2500);
        // The zero-duration slot ends at once with full progress; slot 15 is
        // moved into its place and still reported within the same tick.
        tick_frame('0);
        tick_frame(24'd700);
        tick_frame(24'hFFFFFF);
        // Both remaining entries end here with saturated progress.
        tick_frame(24'd1);
        // Fill every slot; the list is then full.
        for (int k = 0; k < SLOTS; k++)
            start_slot(SLOT_W'(k), (k == SLOTS - 1) ? '1 : 32'(k * 37));

        // Soak at the largest frame time: the short transitions end within
        // two ticks, while the two longest keep running and reporting.
        start_slot(4'd9, '1);
        repeat (SOAK_TICKS)
            tick_frame(24'hFFFFFF);

        // Random part, in three phases.
        repeat (RANDOM_PER_PHASE)
            random_item();
        send_gap   = 79;
        recv_stall = 13;
        repeat (RANDOM_PER_PHASE)
            random_item();
        send_gap   = 0;
        recv_stall = 0;
        repeat (RANDOM_PER_PHASE)
            random_item();

        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        // Drain, then leave time for any stray result to show up.
        while (outstanding != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES)
            @(negedge clk);

        if (errors == 0)
            $display("timed_transition_table_top regression: pass");
        else
            $display("timed_transition_table_top regression: fail");
        $finish;
    end

endmodule

[timed_transition_table_top.f]
+incdir+rtl/core
rtl/core/ttt_pkg.sv
rtl/core/ttt_ram.sv
rtl/core/ttt_div.sv
rtl/core/timed_transition_table_top.sv
tb/timed_transition_table_checker.sv
tb/timed_transition_table_top_test.sv
